// ----- design/b64d_pkg.sv -----
package b64d_pkg;

    // Output byte queue geometry
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int FIFO_LW    = 4;

    // Most bytes a single closing window can produce
    localparam int MAX_GROUP  = 3;

    // Sextet codes of the two symbol characters
    localparam logic [5:0] SXT_PLUS  = 6'd62;
    localparam logic [5:0] SXT_SLASH = 6'd63;

    // Character classes
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_DIG_0 = 8'h30;
    localparam logic [7:0] CH_DIG_9 = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_PAD   = 8'h3D;

    // One decoded sextet; ok clear for characters outside the alphabet
    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } t_sextet;

    // Bytes released by one closing window, first byte in slot 0
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][7:0] bytes;
    } t_push;

    // Alphabet lookup; '=' counts as a zero sextet
    function automatic t_sextet sextet_of(input logic [7:0] c);
        t_sextet s;
        s.ok  = 1'b1;
        s.val = '0;
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            s.val = 6'(c - CH_UP_A);
        end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
            s.val = 6'(c - CH_LO_A + 8'd26);
        end else if (c >= CH_DIG_0 && c <= CH_DIG_9) begin
            s.val = 6'(c - CH_DIG_0 + 8'd52);
        end else if (c == CH_PLUS) begin
            s.val = SXT_PLUS;
        end else if (c == CH_SLASH) begin
            s.val = SXT_SLASH;
        end else if (c == CH_PAD) begin
            s.val = '0;
        end else begin
            s.ok = 1'b0;
        end
        return s;
    endfunction

endpackage

// ----- design/b64d_ifs.sv -----
// Character request channel
interface b64d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_final;

    modport source (output valid, output char_code, output is_final, input ready);
    modport sink   (input valid, input char_code, input is_final, output ready);
endinterface

// Decoded byte request channel
interface b64d_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       run_end;

    modport source (output valid, output data_byte, output run_end, input ready);
    modport sink   (input valid, input data_byte, input run_end, output ready);
endinterface

// ----- design/b64d_decode.sv -----
module b64d_decode
    import b64d_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_char,
    input  logic       i_final,
    output t_push      o_push
);

    logic        r_in_vld;
    logic [7:0]  r_char;
    logic        r_final;

    logic [1:0]  r_win_pos;
    logic [2:0]  r_sxt_cnt;
    logic [23:0] r_acc;

    t_sextet     w_sxt;
    logic        w_shift;
    logic        w_close;
    logic [2:0]  n_sxt_cnt;
    logic [23:0] n_acc;
    logic [23:0] w_padded;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= i_take;
        end
        if (i_take) begin
            r_char  <= i_char;
            r_final <= i_final;
        end
    end

    // Lookup and shift into the accumulator
    always_comb begin
        w_sxt     = sextet_of(r_char);
        w_shift   = w_sxt.ok && (r_sxt_cnt < 3'd4);
        n_acc     = w_shift ? {r_acc[17:0], w_sxt.val} : r_acc;
        n_sxt_cnt = r_sxt_cnt + {2'b0, w_shift};
        w_close   = r_in_vld && (r_final || r_win_pos == 2'd3);
    end

    // Pad to four sextets
    always_comb begin
        unique case (n_sxt_cnt)
            3'd0:    w_padded = '0;
            3'd1:    w_padded = {n_acc[5:0], 18'b0};
            3'd2:    w_padded = {n_acc[11:0], 12'b0};
            3'd3:    w_padded = {n_acc[17:0], 6'b0};
            default: w_padded = n_acc;
        endcase
    end

    // Bytes released on close: one fewer than the sextets, none below two
    always_comb begin
        o_push.bytes[0] = w_padded[23:16];
        o_push.bytes[1] = w_padded[15:8];
        o_push.bytes[2] = w_padded[7:0];
        if (w_close && n_sxt_cnt >= 3'd2) begin
            o_push.cnt = 2'(n_sxt_cnt - 3'd1);
        end else begin
            o_push.cnt = '0;
        end
    end

    // Window state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_pos <= '0;
            r_sxt_cnt <= '0;
            r_acc     <= '0;
        end else if (w_close) begin
            r_win_pos <= '0;
            r_sxt_cnt <= '0;
            r_acc     <= '0;
        end else if (r_in_vld) begin
            r_win_pos <= r_win_pos + 2'd1;
            r_sxt_cnt <= n_sxt_cnt;
            r_acc     <= n_acc;
        end
    end

endmodule

// ----- design/b64d_byte_fifo.sv -----
module b64d_byte_fifo
    import b64d_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_push              i_push,
    input  logic               i_pop,
    output logic               o_room,
    output logic               o_valid,
    output logic [7:0]         o_data,
    output logic               o_last,
    output logic [FIFO_LW-1:0] o_level
);

    logic [8:0]         r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [FIFO_LW-1:0] r_level;
    logic               w_pop;
    logic [FIFO_LW-1:0] w_after;

    assign w_pop   = i_pop && (r_level != '0);
    assign o_valid = (r_level != '0);
    assign o_data  = r_mem[r_rd][8:1];
    assign o_last  = r_mem[r_rd][0];
    assign o_level = r_level;

    // Room for a full group beyond what is stored and what is about to land
    assign w_after = r_level + FIFO_LW'(i_push.cnt);
    assign o_room  = (w_after <= FIFO_LW'(FIFO_DEPTH - MAX_GROUP));

    // Group write, run-end flag on the last byte of the group
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_GROUP; k++) begin
            if (2'(k) < i_push.cnt) begin
                r_mem[r_wr + FIFO_AW'(k)] <= {i_push.bytes[k], (2'(k) == i_push.cnt - 2'd1)};
            end
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_level <= '0;
        end else begin
            r_wr    <= r_wr + FIFO_AW'(i_push.cnt);
            r_rd    <= r_rd + FIFO_AW'(w_pop);
            r_level <= r_level + FIFO_LW'(i_push.cnt) - FIFO_LW'(w_pop);
        end
    end

endmodule

// ----- design/base64_stream_decoder_unit.sv -----
// Channel    Dir  Payload                  Request taken when
// i_chr      in   char_code[7:0], is_final valid && ready
// o_byte     out  data_byte[7:0], run_end  valid && ready
//
// One character per cycle while ready is high; a character is registered, looked
// up and shifted in the next cycle, and any bytes of a closing window enter an
// 8-entry byte queue; a byte is valid once written there. Bytes leave one per
// cycle while the receiver is ready; input ready drops while the queue cannot
// hold another full group of three bytes.
// Reset (synchronous, active low) empties the queue and clears the window.
module base64_stream_decoder_unit
    import b64d_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    b64d_in_if.sink           i_chr,
    b64d_out_if.source        o_byte
);

    logic               w_take;
    logic               w_room;
    logic [FIFO_LW-1:0] w_level;
    t_push              w_push;

    assign w_take      = i_chr.valid && i_chr.ready;
    assign i_chr.ready = w_room;

    // Window accumulation and byte assembly
    b64d_decode u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (w_take),
        .i_char  (i_chr.char_code),
        .i_final (i_chr.is_final),
        .o_push  (w_push)
    );

    // Output byte queue
    b64d_byte_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (o_byte.ready),
        .o_room  (w_room),
        .o_valid (o_byte.valid),
        .o_data  (o_byte.data_byte),
        .o_last  (o_byte.run_end),
        .o_level (w_level)
    );

    // Queue never holds more than its depth
    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_level <= FIFO_LW'(FIFO_DEPTH))
        else $error("byte queue overfilled");

    // A taken character leaves room for whatever its window releases
    a_room_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |=> (w_level + FIFO_LW'(w_push.cnt)) <= FIFO_LW'(FIFO_DEPTH))
        else $error("group would not fit in byte queue");

    // Released bytes show up at the output the next cycle
    a_push_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.cnt != 2'd0) |=> o_byte.valid)
        else $error("pushed bytes not presented");

endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
    import b64d_pkg::*;

    localparam int MAX_GAP       = 17;
    localparam int HOLD_CYCLES   = 64;
    localparam int RANDOM_ITEMS  = 200;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT   = 200000;

    // Decoder predictor and store of bytes still owed by the block
    class b64_scoreboard;
        typedef struct packed {
            logic [7:0] data_byte;
            logic       run_end;
        } decoded_t;

        decoded_t    owed_q[$];
        logic [1:0]  slot;
        logic [2:0]  sextets;
        logic [23:0] acc;
        int          errors;
        int          windows_closed;
        int          bytes_checked;

        function new();
            errors         = 0;
            windows_closed = 0;
            bytes_checked  = 0;
            clear_window();
        endfunction

        function void clear_window();
            slot    = 2'd0;
            sextets = 3'd0;
            acc     = 24'd0;
        endfunction

        // Alphabet lookup; '=' decodes to zero, everything else is rejected
        function t_sextet decode_char(logic [7:0] c);
            t_sextet s;
            s.ok  = 1'b1;
            s.val = 6'd0;
            if (c >= CH_UP_A && c <= CH_UP_Z)
                s.val = c[5:0] - CH_UP_A[5:0];
            else if (c >= CH_LO_A && c <= CH_LO_Z)
                s.val = c[5:0] - CH_LO_A[5:0] + 6'd26;
            else if (c >= CH_DIG_0 && c <= CH_DIG_9)
                s.val = c[5:0] - CH_DIG_0[5:0] + 6'd52;
            else if (c == CH_PLUS)
                s.val = SXT_PLUS;
            else if (c == CH_SLASH)
                s.val = SXT_SLASH;
            else if (c != CH_PAD)
                s.ok = 1'b0;
            return s;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        task report(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        // Accepted character: advance the window, queue any bytes it releases
        function void note_char(logic [7:0] c, logic fin);
            t_sextet     s;
            logic [2:0]  pos;
            logic [23:0] padded;
            int          nbytes;
            decoded_t    d;
            s = decode_char(c);
            if (s.ok && sextets < 3'd4) begin
                acc     = {acc[17:0], s.val};
                sextets = sextets + 3'd1;
            end
            pos = {1'b0, slot} + 3'd1;
            if (pos < 3'd4 && !fin) begin
                slot = pos[1:0];
                return;
            end
            // window closes: pad to four sextets, emit MSB first
            padded = acc;
            for (int k = int'(sextets); k < 4; k++)
                padded = {padded[17:0], 6'd0};
            nbytes = (sextets >= 3'd2) ? int'(sextets) - 1 : 0;
            for (int i = 0; i < nbytes; i++) begin
                d.data_byte = padded[23 - 8 * i -: 8];
                d.run_end   = (i == nbytes - 1);
                owed_q.push_back(d);
            end
            windows_closed++;
            clear_window();
        endfunction

        // Byte taken from the block: compare with the oldest owed byte
        task check_byte(logic [7:0] data, logic run_end);
            decoded_t d;
            bytes_checked++;
            if (owed_q.size() == 0) begin
                report($sformatf("unexpected byte %02h run_end %0b", data, run_end));
                return;
            end
            d = owed_q.pop_front();
            if (data !== d.data_byte)
                report($sformatf("data_byte %02h, want %02h", data, d.data_byte));
            if (run_end !== d.run_end)
                report($sformatf("run_end %0b, want %0b (byte %02h)",
                                 run_end, d.run_end, d.data_byte));
        endtask

        task flag_leftovers();
            if (owed_q.size() != 0)
                report($sformatf("%0d bytes never arrived", owed_q.size()));
        endtask
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    b64d_in_if  chr_if ();
    b64d_out_if byte_if ();

    base64_stream_decoder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_chr   (chr_if),
        .o_byte  (byte_if)
    );

    b64_scoreboard sb = new();

    bit in_calm     = 1'b0;
    bit out_calm    = 1'b0;
    bit hold_output = 1'b0;
    int chars_sent  = 0;
    int holds_done  = 0;
    int cycle_count = 0;

    // Clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Cycle counter for the run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("run limit of %0d cycles reached, %0d bytes owed",
                 CYCLE_LIMIT, sb.pending());
        $display("FAILURE");
        $finish;
    end

    // One character request; valid stays up when the next one follows at once
    task automatic send_char(input logic [7:0] c, input logic fin);
        int gap;
        gap = in_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            chr_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        chr_if.valid     <= 1'b1;
        chr_if.char_code <= c;
        chr_if.is_final  <= fin;
        do @(posedge i_clk); while (!(chr_if.valid && chr_if.ready));
        sb.note_char(c, fin);
        chars_sent++;
    endtask

    function automatic logic [7:0] random_b64_char();
        int r;
        r = $urandom_range(0, 64);
        if (r < 26) return CH_UP_A + 8'(r);
        if (r < 52) return CH_LO_A + 8'(r - 26);
        if (r < 62) return CH_DIG_0 + 8'(r - 52);
        if (r == 62) return CH_PLUS;
        if (r == 63) return CH_SLASH;
        return CH_PAD;
    endfunction

    // Encoded text of len characters, final flag on the last, some stray bytes
    task automatic send_text(input int len, input int stray_pct);
        logic [7:0] c;
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < stray_pct)
                c = 8'($urandom_range(0, 255));
            else
                c = random_b64_char();
            send_char(c, i == len - 1);
        end
    endtask

    // Sender stops offering and waits until every owed byte has arrived
    task automatic drain_results();
        chr_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    // Byte receiver: random stalls, calm stretches, one long hold on request
    initial begin
        int gap;
        byte_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (hold_output) begin
                byte_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_output = 1'b0;
                holds_done++;
            end else begin
                gap = out_calm ? 0 : $urandom_range(0, MAX_GAP);
                if (gap > 0) begin
                    byte_if.ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            byte_if.ready <= 1'b1;
            do @(posedge i_clk); while (!(byte_if.valid && byte_if.ready));
            sb.check_byte(byte_if.data_byte, byte_if.run_end);
            if ($urandom_range(0, 11) == 0) out_calm = !out_calm;
        end
    end

    // Stimulus
    initial begin
        int random_start;
        chr_if.valid     <= 1'b0;
        chr_if.char_code <= 8'h00;
        chr_if.is_final  <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // full window over the letter-range ends
        send_char(CH_UP_A, 1'b0);
        send_char(CH_UP_Z, 1'b0);
        send_char(CH_LO_A, 1'b0);
        send_char(CH_LO_Z, 1'b0);
        // final on the fourth slot; digit and symbol ends
        send_char(CH_DIG_0, 1'b0);
        send_char(CH_DIG_9, 1'b0);
        send_char(CH_PLUS, 1'b0);
        send_char(CH_SLASH, 1'b1);
        // interior pad as zero, final closes after three slots
        send_char(CH_UP_A, 1'b0);
        send_char(CH_PAD, 1'b0);
        send_char(CH_SLASH, 1'b1);
        // window of invalid bytes only: nothing out
        send_char(8'h00, 1'b0);
        send_char(8'h40, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char(8'h7B, 1'b0);
        // single sextet closed by final: too few for a byte
        send_char(CH_LO_A + 8'd6, 1'b1);
        // two sextets, invalid byte carries final
        send_char(8'h54, 1'b0);
        send_char(8'h57, 1'b0);
        send_char(8'h0A, 1'b1);
        // pad alone as final
        send_char(CH_PAD, 1'b1);
        // invalid byte mid-window, three sextets at window end
        send_char(CH_LO_Z, 1'b0);
        send_char(8'h7F, 1'b0);
        send_char(CH_DIG_9, 1'b0);
        send_char(CH_UP_Z, 1'b0);
        drain_results();

        // back-pressure: receiver holds off while full windows stream in
        hold_output = 1'b1;
        in_calm     = 1'b1;
        send_text(24, 0);
        in_calm = 1'b0;
        drain_results();

        // random texts, mostly well formed, plus loose noise bytes
        random_start = chars_sent;
        while (chars_sent - random_start < RANDOM_ITEMS) begin
            if ($urandom_range(0, 4) == 0) in_calm = !in_calm;
            if ($urandom_range(0, 9) < 7) begin
                send_text($urandom_range(1, 12), 10);
            end else begin
                repeat ($urandom_range(1, 4))
                    send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 14) == 0) drain_results();
        end

        chr_if.valid <= 1'b0;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        sb.flag_leftovers();

        $display("%0d characters in, %0d windows closed, %0d bytes checked",
                 chars_sent, sb.windows_closed, sb.bytes_checked);
        $display("%0d long receiver holds, %0d mismatches", holds_done, sb.errors);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
